// File: rtl/core/rtr_pkg.sv
// Shared types, codes and helpers for the I2C register transfer sequencer.
`timescale 1ns / 1ps

package rtr_pkg;

    localparam int unsigned MAX_TRANSFER = 256;

    localparam logic [9:0] BYTE_TIME_RESET = 10'd90;

    // command codes carried on the slave-side tuser
    localparam logic [2:0] CMD_START      = 3'd0;
    localparam logic [2:0] CMD_FIFO_SPACE = 3'd1;
    localparam logic [2:0] CMD_BYTE_RX    = 3'd2;
    localparam logic [2:0] CMD_ABORT      = 3'd3;
    localparam logic [2:0] CMD_STOP_DET   = 3'd4;
    localparam logic [2:0] CMD_TIMER_EXP  = 3'd5;

    // result kinds carried on the master-side tuser
    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_CMD_WORD  = 3'd1;
    localparam logic [2:0] KIND_STORE     = 3'd2;
    localparam logic [2:0] KIND_DONE      = 3'd3;
    localparam logic [2:0] KIND_TIMER     = 3'd4;
    localparam logic [2:0] KIND_ABORT_REQ = 3'd5;

    // completion status codes
    localparam logic [2:0] ST_SUCCESS     = 3'd0;
    localparam logic [2:0] ST_USER_ABORT  = 3'd1;
    localparam logic [2:0] ST_ARB_LOST    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN     = 3'd3;
    localparam logic [2:0] ST_BAD_REG     = 3'd4;
    localparam logic [2:0] ST_BAD_DEV     = 3'd5;
    localparam logic [2:0] ST_TIMEOUT     = 3'd6;
    localparam logic [2:0] ST_RESET_REQ   = 3'd7;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_REGADR = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_WAIT   = 5'b01000,
        PH_RESET  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  target_address;
        logic [1:0]  address_length_code;
        logic [31:0] register_address;
        logic [8:0]  transfer_length;
        logic        is_write;
        logic [7:0]  data_byte;
        logic [5:0]  abort_flags;
    } t_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  command_byte;
        logic        command_read;
        logic        command_restart;
        logic        command_stop;
        logic [7:0]  store_index;
        logic [7:0]  store_byte;
        logic [2:0]  status_code;
        logic [18:0] timer_load;
        logic [6:0]  device_select;
        logic        feed_done;
    } t_result;

    function automatic logic [2:0] addr_bytes(input logic [1:0] code);
        logic [2:0] n;
        case (code)
            2'd0:    n = 3'd0;
            2'd1:    n = 3'd1;
            2'd2:    n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/core/i2c_register_transfer_sequencer.sv
// A slave beat is held in the input register; its result is held in the result register.
// Throughput: one beat per cycle unless stalled; every accepted beat yields one result beat.
// Rate is set by the input register, the single-pass sequencer logic and the result register.
// A master-side stall holds both registers and drops o_s_tready only once both are full.
// Reset is synchronous, active low: transfer state goes idle and byte time returns to 90 us.
`timescale 1ns / 1ps

module i2c_register_transfer_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: byte time in microseconds
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: target_address[6:0], address_length_code[8:7], register_address[40:9],
    //        transfer_length[49:41], is_write[50], data_byte[58:51], abort_flags[64:59]
    input  logic [71:0] i_s_tdata,
    // tuser: command[2:0]
    input  logic [2:0]  i_s_tuser,
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: command_byte[7:0], command_read[8], command_restart[9], command_stop[10],
    //        store_index[18:11], store_byte[26:19], status_code[29:27],
    //        timer_load[48:30], device_select[55:49], feed_done[56]
    output logic [63:0] o_m_tdata,
    // tuser: result_kind[2:0]
    output logic [2:0]  o_m_tuser
);

    logic [9:0]       r_byte_time;
    logic             r_in_valid;
    rtr_pkg::t_item   r_in_item;
    logic             r_out_valid;
    rtr_pkg::t_result r_out;
    rtr_pkg::t_result w_res;
    logic             w_out_ready;
    logic             w_fire;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_time <= rtr_pkg::BYTE_TIME_RESET;
        end else if (i_cfg_valid) begin
            r_byte_time <= i_cfg_data;
        end
    end

    assign w_out_ready = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || w_out_ready;
    assign w_fire      = r_in_valid && w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_item.command             <= i_s_tuser;
            r_in_item.target_address      <= i_s_tdata[6:0];
            r_in_item.address_length_code <= i_s_tdata[8:7];
            r_in_item.register_address    <= i_s_tdata[40:9];
            r_in_item.transfer_length     <= i_s_tdata[49:41];
            r_in_item.is_write            <= i_s_tdata[50];
            r_in_item.data_byte           <= i_s_tdata[58:51];
            r_in_item.abort_flags         <= i_s_tdata[64:59];
        end
    end

    rtr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in_item),
        .i_byte_time (r_byte_time),
        .o_result    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.result_kind;
    assign o_m_tdata  = {7'd0,
                         r_out.feed_done,
                         r_out.device_select,
                         r_out.timer_load,
                         r_out.status_code,
                         r_out.store_byte,
                         r_out.store_index,
                         r_out.command_stop,
                         r_out.command_restart,
                         r_out.command_read,
                         r_out.command_byte};

endmodule

// File: rtl/core/rtr_seq.sv
// Transfer state and per-beat result logic of the register transfer sequencer.
`timescale 1ns / 1ps

module rtr_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  rtr_pkg::t_item  i_item,
    input  logic [9:0]      i_byte_time,
    output rtr_pkg::t_result o_result
);

    rtr_pkg::t_phase r_phase, n_phase;
    logic [8:0]  r_sent_count, n_sent_count;
    logic [8:0]  r_recv_count, n_recv_count;
    logic [31:0] r_held_radr, n_held_radr;
    logic [1:0]  r_held_alc, n_held_alc;
    logic [8:0]  r_held_length, n_held_length;
    logic        r_held_write, n_held_write;
    logic        r_timed_out, n_timed_out;

    rtr_pkg::t_result w_res;
    logic [8:0]  w_len;
    logic [9:0]  w_total;
    logic [19:0] w_prod;
    logic [9:0]  w_sent_inc;
    logic        w_last;
    logic        w_busy;
    logic [2:0]  w_abort_st;
    logic [31:0] w_radr_shift;

    assign w_busy = (r_phase == rtr_pkg::PH_REGADR) || (r_phase == rtr_pkg::PH_DATA)
                 || (r_phase == rtr_pkg::PH_WAIT);

    // clamp the requested length into 1..MAX_TRANSFER
    always_comb begin
        w_len = i_item.transfer_length;
        if (w_len == 9'd0) begin
            w_len = 9'd1;
        end
        if (32'(i_item.transfer_length) > rtr_pkg::MAX_TRANSFER) begin
            w_len = 9'(rtr_pkg::MAX_TRANSFER);
        end
    end

    assign w_total = 10'(w_len) + 10'(rtr_pkg::addr_bytes(i_item.address_length_code))
                   + 10'(!i_item.is_write) + 10'd2;
    assign w_prod  = 20'(w_total) * 20'(i_byte_time);

    assign w_sent_inc   = 10'(r_sent_count) + 10'd1;
    assign w_last       = w_sent_inc >= 10'(r_held_length);
    assign w_radr_shift = r_held_radr >> {r_sent_count[1:0], 3'b000};

    always_comb begin
        if (r_timed_out) begin
            w_abort_st = rtr_pkg::ST_TIMEOUT;
        end else if (i_item.abort_flags[5]) begin
            w_abort_st = rtr_pkg::ST_BAD_DEV;
        end else if (i_item.abort_flags[4]) begin
            w_abort_st = rtr_pkg::ST_BAD_REG;
        end else if (i_item.abort_flags[3] || i_item.abort_flags[2]) begin
            w_abort_st = rtr_pkg::ST_UNKNOWN;
        end else if (i_item.abort_flags[1]) begin
            w_abort_st = rtr_pkg::ST_ARB_LOST;
        end else if (i_item.abort_flags[0]) begin
            w_abort_st = rtr_pkg::ST_USER_ABORT;
        end else begin
            w_abort_st = rtr_pkg::ST_UNKNOWN;
        end
    end

    always_comb begin
        w_res         = '0;
        n_phase       = r_phase;
        n_sent_count  = r_sent_count;
        n_recv_count  = r_recv_count;
        n_held_radr   = r_held_radr;
        n_held_alc    = r_held_alc;
        n_held_length = r_held_length;
        n_held_write  = r_held_write;
        n_timed_out   = r_timed_out;
        if (r_phase != rtr_pkg::PH_RESET) begin
            case (i_item.command)
                rtr_pkg::CMD_START: begin
                    if (r_phase == rtr_pkg::PH_IDLE) begin
                        n_held_radr   = i_item.register_address;
                        n_held_alc    = i_item.address_length_code;
                        n_held_length = w_len;
                        n_held_write  = i_item.is_write;
                        n_sent_count  = '0;
                        n_recv_count  = '0;
                        n_timed_out   = 1'b0;
                        n_phase       = (i_item.address_length_code == 2'd0)
                                        ? rtr_pkg::PH_DATA : rtr_pkg::PH_REGADR;
                        w_res.result_kind   = rtr_pkg::KIND_TIMER;
                        w_res.timer_load    = w_prod[18:0];
                        w_res.device_select = i_item.target_address;
                    end
                end
                rtr_pkg::CMD_FIFO_SPACE: begin
                    if (r_phase == rtr_pkg::PH_REGADR) begin
                        w_res.result_kind  = rtr_pkg::KIND_CMD_WORD;
                        w_res.command_byte = w_radr_shift[7:0];
                        n_sent_count       = w_sent_inc[8:0];
                        if (w_sent_inc >= 10'(rtr_pkg::addr_bytes(r_held_alc))) begin
                            n_sent_count = '0;
                            n_phase      = rtr_pkg::PH_DATA;
                        end
                    end else if (r_phase == rtr_pkg::PH_DATA) begin
                        w_res.result_kind     = rtr_pkg::KIND_CMD_WORD;
                        w_res.command_byte    = r_held_write ? i_item.data_byte : 8'd0;
                        w_res.command_read    = !r_held_write;
                        // repeated start only on the first data word after an address
                        w_res.command_restart = (r_sent_count == 9'd0) && (r_held_alc != 2'd0);
                        w_res.command_stop    = w_last;
                        w_res.feed_done       = w_last;
                        n_sent_count          = w_sent_inc[8:0];
                        if (w_last) begin
                            n_phase = rtr_pkg::PH_WAIT;
                        end
                    end else begin
                        w_res.feed_done = 1'b1;
                    end
                end
                rtr_pkg::CMD_BYTE_RX: begin
                    if ((r_phase == rtr_pkg::PH_DATA || r_phase == rtr_pkg::PH_WAIT)
                        && !r_held_write && (r_recv_count < r_held_length)) begin
                        w_res.result_kind = rtr_pkg::KIND_STORE;
                        w_res.store_index = r_recv_count[7:0];
                        w_res.store_byte  = i_item.data_byte;
                        n_recv_count      = r_recv_count + 9'd1;
                    end
                end
                rtr_pkg::CMD_ABORT: begin
                    if (w_busy) begin
                        w_res.result_kind = rtr_pkg::KIND_DONE;
                        w_res.status_code = w_abort_st;
                        n_phase           = rtr_pkg::PH_IDLE;
                    end
                end
                rtr_pkg::CMD_STOP_DET: begin
                    if (w_busy) begin
                        w_res.result_kind = rtr_pkg::KIND_DONE;
                        w_res.status_code = rtr_pkg::ST_SUCCESS;
                        n_phase           = rtr_pkg::PH_IDLE;
                    end
                end
                rtr_pkg::CMD_TIMER_EXP: begin
                    if (w_busy) begin
                        if (!r_timed_out) begin
                            n_timed_out       = 1'b1;
                            w_res.result_kind = rtr_pkg::KIND_ABORT_REQ;
                            w_res.timer_load  = 19'({i_byte_time, 1'b0});
                        end else begin
                            // second expiry: lock up until reset
                            n_phase           = rtr_pkg::PH_RESET;
                            w_res.result_kind = rtr_pkg::KIND_DONE;
                            w_res.status_code = rtr_pkg::ST_RESET_REQ;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= rtr_pkg::PH_IDLE;
            r_sent_count  <= '0;
            r_recv_count  <= '0;
            r_held_radr   <= '0;
            r_held_alc    <= '0;
            r_held_length <= '0;
            r_held_write  <= 1'b0;
            r_timed_out   <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_sent_count  <= n_sent_count;
            r_recv_count  <= n_recv_count;
            r_held_radr   <= n_held_radr;
            r_held_alc    <= n_held_alc;
            r_held_length <= n_held_length;
            r_held_write  <= n_held_write;
            r_timed_out   <= n_timed_out;
        end
    end

`ifndef SYNTH
    a_stop_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_res.result_kind == rtr_pkg::KIND_CMD_WORD && w_res.command_stop)
        |=> (r_phase == rtr_pkg::PH_WAIT))
        else $error("stop word did not move the sequencer to wait");

    a_reset_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rtr_pkg::PH_RESET) |=> (r_phase == rtr_pkg::PH_RESET))
        else $error("reset-needed phase was left without reset");

    a_recv_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recv_count <= r_held_length)
        else $error("received count ran past the transfer length");

    a_regadr_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rtr_pkg::PH_REGADR)
        |-> (10'(r_sent_count) < 10'(rtr_pkg::addr_bytes(r_held_alc))))
        else $error("address byte count ran past the address length");
`endif

endmodule
